// ===== hdl/pscs_pkg.sv =====
// ----------------------------------------------------------------------------
// pscs_pkg
// Shared types, constants and tables of the plucked-string chord synthesizer.
// ----------------------------------------------------------------------------
package pscs_pkg;

  localparam int unsigned VOICES_DEF    = 3;
  localparam int unsigned MAX_DELAY_DEF = 120;

  localparam logic [7:0]  SEED_RESET  = 8'hA5;
  localparam logic [12:0] GATE_START  = 13'd5080;
  localparam logic [12:0] HOLD_LEVEL  = 13'd4080;
  localparam logic [6:0]  MIN_LEN     = 7'd15;
  localparam logic [6:0]  CLIP_RESET  = 7'd38;
  localparam logic [4:0]  FILT_RESET  = 5'd16;
  localparam logic [7:0]  MIDSCALE    = 8'd128;

  localparam logic [0:0] REG_CLIP = 1'b0;
  localparam logic [0:0] REG_FILT = 1'b1;

  typedef enum logic [2:0] {
    MODE_SAMPLE  = 3'd0,
    MODE_PLUCK   = 3'd1,
    MODE_MUTE    = 3'd2,
    MODE_MS      = 3'd3,
    MODE_VIB     = 3'd4,
    MODE_VIBRST  = 3'd5,
    MODE_NOP6    = 3'd6,
    MODE_NOP7    = 3'd7
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_PLUCK,
    ST_SRD_CUR,
    ST_SRD_NXT,
    ST_SWR,
    ST_MIX,
    ST_SCALE,
    ST_OUT
  } state_e;

  function automatic logic [6:0] len_lookup(input logic [5:0] idx);
    logic [6:0] r;
    begin
      case (idx)
        6'd0: r = 7'd119;  6'd1: r = 7'd113;  6'd2: r = 7'd106;  6'd3: r = 7'd100;
        6'd4: r = 7'd95;   6'd5: r = 7'd89;   6'd6: r = 7'd84;   6'd7: r = 7'd80;
        6'd8: r = 7'd75;   6'd9: r = 7'd71;   6'd10: r = 7'd67;  6'd11: r = 7'd63;
        6'd12: r = 7'd60;  6'd13: r = 7'd56;  6'd14: r = 7'd53;  6'd15: r = 7'd50;
        6'd16: r = 7'd47;  6'd17: r = 7'd45;  6'd18: r = 7'd42;  6'd19: r = 7'd40;
        6'd20: r = 7'd38;  6'd21: r = 7'd36;  6'd22: r = 7'd34;  6'd23: r = 7'd32;
        6'd24: r = 7'd30;  6'd25: r = 7'd28;  6'd26: r = 7'd27;  6'd27: r = 7'd25;
        6'd28: r = 7'd24;  6'd29: r = 7'd22;  6'd30: r = 7'd21;  6'd31: r = 7'd20;
        6'd32: r = 7'd19;  6'd33: r = 7'd18;  6'd34: r = 7'd17;  6'd35: r = 7'd16;
        6'd36: r = 7'd15;
        default: r = 7'd15;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] xorshift(input logic [7:0] s);
    logic [7:0] x;
    begin
      x = s;
      x = x ^ (x << 3);
      x = x ^ (x >> 5);
      x = x ^ (x << 4);
      return x;
    end
  endfunction

endpackage

// ===== hdl/plucked_string_chord_synth_top.sv =====
// ----------------------------------------------------------------------------
// plucked_string_chord_synth_top
// Three-voice plucked-string chord synthesizer around one delay-line memory.
// ----------------------------------------------------------------------------
// Channel   Signals                                   Direction
// in        in_valid_i/in_ready_o, mode/note/depth    sink
// out       out_valid_o/out_ready_i, pwm_level/active source
// cfg       cfg_valid_i/cfg_ready_o, index/data       sink
//
// One item at a time. A sample tick walks the voices one after another over the single
// memory read port (read current, read neighbor, write back), then mixes and scales.
// A pluck fills each voice's line in turn; a mute walks the current lines the same way.
// A vibrato tick that acts passes a scale state, other items go from decode straight
// to the output, and the next item can be taken in the cycle after a beat is handed
// over. After reset a clearing pass sets all VOICES*MAX_DELAY (360) memory entries to
// midscale; no item is accepted meanwhile. A finished beat waits in the output
// register while the next item runs; only the hand-over to that register stalls.
module plucked_string_chord_synth_top #(
  parameter int unsigned VOICES    = pscs_pkg::VOICES_DEF,
  parameter int unsigned MAX_DELAY = pscs_pkg::MAX_DELAY_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] mode_i,
  input  logic [5:0] note_i,
  input  logic [7:0] vibrato_depth_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] pwm_level_o,
  output logic       active_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned DEPTH = VOICES * MAX_DELAY;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [6:0]  MAXD  = 7'(MAX_DELAY);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;
  logic       we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  pscs_pkg::state_e state_q, state_d;
  logic [6:0] clip_q;
  logic [4:0] filt_q;
  logic [6:0] head_q [VOICES];
  logic [6:0] alen_q [VOICES];
  logic [6:0] plen_q [VOICES];
  logic [6:0] head_d [VOICES];
  logic [6:0] alen_d [VOICES];
  logic [6:0] plen_d [VOICES];
  logic [4:0] skip_q, skip_d;
  logic [12:0] gate_q, gate_d;
  logic [7:0] gain_q, gain_d;
  logic       muted_q, muted_d;
  logic [7:0] seed_q, seed_d;
  logic signed [4:0] lfo_q, lfo_d;
  logic       rising_q, rising_d;
  logic [7:0] level_q, level_d;
  logic       ovalid_q, ovalid_d;
  logic [7:0] opwm_q;
  logic       oact_q;
  logic       out_load;
  logic       init_q, init_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [2:0] mode_q, mode_d;
  logic [5:0] note_q, note_d;
  logic [7:0] depth_q, depth_d;
  logic [VW-1:0] v_q, v_d;
  logic [6:0] j_q, j_d;
  logic [5:0] vnote_q, vnote_d;
  logic [7:0] cur_q, cur_d;
  logic       filt_on_q, filt_on_d;
  logic signed [9:0] mix_q, mix_d;
  logic signed [7:0] clipped_q, clipped_d;

  logic [6:0] len_now, len_cl, np;
  logic [5:0] tidx;
  logic [AW-1:0] base;
  logic [7:0] nz;
  logic signed [9:0] m2, lim;
  logic signed [17:0] prod;
  logic signed [10:0] outv;
  logic signed [3:0] delta;
  logic [3:0] mag;
  logic signed [8:0] nl;
  logic [4:0] skip_inc;

  assign in_ready_o  = (state_q == pscs_pkg::ST_IDLE) && init_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = ovalid_q;
  assign pwm_level_o = opwm_q;
  assign active_o    = oact_q;

  assign base     = AW'(v_q) * AW'(MAX_DELAY);
  assign tidx     = vnote_q - 6'd8;
  assign len_now  = pscs_pkg::len_lookup(tidx);
  assign len_cl   = (len_now > MAXD) ? MAXD : len_now;
  assign np       = ((head_q[v_q] + 7'd1) >= alen_q[v_q]) ? 7'd0 : head_q[v_q] + 7'd1;
  assign nz       = pscs_pkg::xorshift(seed_q);
  assign skip_inc = skip_q + 5'd1;

  always_comb begin
    lim = 10'(clip_q);
    // The offset sum reaches 765, so it is formed one bit wider.
    m2  = 10'((11'(mix_q) + 11'sd384) >>> 2) - 10'sd96;
    if (m2 > lim) m2 = lim;
    if (m2 < -lim) m2 = -lim;
    prod = 18'(clipped_q) * $signed({10'd0, gain_q});
    outv = 11'((prod + 18'sd24576) >>> 8) - 11'sd96 + 11'sd128;
    mag  = (lfo_q < 0) ? 4'(-lfo_q) : 4'(lfo_q);
    delta = (depth_q >= 8'd3) ? 4'(mag >> 2) : 4'(mag >> 3);
    if (lfo_q < 0) delta = -delta;
  end

  always_comb begin
    state_d = state_q;
    head_d = head_q; alen_d = alen_q; plen_d = plen_q;
    skip_d = skip_q; gate_d = gate_q; gain_d = gain_q; muted_d = muted_q;
    seed_d = seed_q; lfo_d = lfo_q; rising_d = rising_q; level_d = level_q;
    ovalid_d = ovalid_q; init_d = init_q; clr_d = clr_q;
    mode_d = mode_q; note_d = note_q; depth_d = depth_q;
    v_d = v_q; j_d = j_q; vnote_d = vnote_q; cur_d = cur_q;
    filt_on_d = filt_on_q; mix_d = mix_q; clipped_d = clipped_q;
    we = 1'b0; waddr = '0; wdata = pscs_pkg::MIDSCALE;
    raddr = base + AW'(head_q[v_q]);
    nl = '0;
    out_load = 1'b0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    if (!init_q) begin
      we = 1'b1; waddr = clr_q;
      clr_d = clr_q + AW'(1);
      if (clr_q == AW'(DEPTH - 1)) init_d = 1'b1;
    end
    unique case (state_q)
      pscs_pkg::ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          mode_d = mode_i; note_d = note_i; depth_d = vibrato_depth_i;
          v_d = '0; j_d = '0;
          state_d = pscs_pkg::ST_DECODE;
        end
      end
      pscs_pkg::ST_DECODE: begin
        state_d = pscs_pkg::ST_OUT;
        case (mode_q)
          pscs_pkg::MODE_SAMPLE: begin
            if (!muted_q) begin
              skip_d = skip_inc;
              filt_on_d = (skip_inc >= filt_q);
              mix_d = '0;
              state_d = pscs_pkg::ST_SRD_CUR;
            end
          end
          pscs_pkg::MODE_PLUCK: begin
            if (note_q >= 6'd8 && note_q <= 6'd32) begin
              vnote_d = note_q;
              seed_d = seed_q ^ 8'({2'b00, note_q} * 8'd17);
              state_d = pscs_pkg::ST_PLUCK;
            end
          end
          pscs_pkg::MODE_MUTE: begin
            gate_d = '0; gain_d = 8'd255; muted_d = 1'b1;
            state_d = pscs_pkg::ST_CLEAR;
          end
          pscs_pkg::MODE_MS: begin
            if (!muted_q) begin
              if (gate_q == '0) begin
                gain_d = '0; muted_d = 1'b1;
              end else begin
                gate_d = gate_q - 13'd1;
                gain_d = (gate_d >= pscs_pkg::HOLD_LEVEL) ? 8'd255 : gate_d[11:4];
              end
            end
          end
          pscs_pkg::MODE_VIB: begin
            if (depth_q != 8'd0 && !muted_q) begin
              lfo_d = rising_q ? lfo_q + 5'sd1 : lfo_q - 5'sd1;
              if (lfo_d >= 5'sd8) begin
                lfo_d = 5'sd8; rising_d = 1'b0;
              end else if (lfo_d <= -5'sd8) begin
                lfo_d = -5'sd8; rising_d = 1'b1;
              end
              mode_d = pscs_pkg::MODE_NOP7;
              state_d = pscs_pkg::ST_SCALE;
            end
          end
          pscs_pkg::MODE_VIBRST: begin
            lfo_d = '0; rising_d = 1'b1;
            for (int v = 0; v < VOICES; v++) begin
              if (head_q[v] >= plen_q[v]) head_d[v] = '0;
              alen_d[v] = plen_q[v];
            end
          end
          default: ;
        endcase
      end
      pscs_pkg::ST_CLEAR: begin
        if (j_q < alen_q[v_q] && j_q < MAXD) begin
          we = 1'b1; waddr = base + AW'(j_q);
          wdata = pscs_pkg::MIDSCALE;
          j_d = j_q + 7'd1;
        end else begin
          j_d = '0;
          if (v_q == VW'(VOICES - 1)) state_d = pscs_pkg::ST_OUT;
          else v_d = v_q + VW'(1);
        end
      end
      pscs_pkg::ST_PLUCK: begin
        if (j_q == '0) begin
          alen_d[v_q] = len_cl; plen_d[v_q] = len_cl; head_d[v_q] = '0;
        end
        if (j_q < len_cl) begin
          seed_d = nz;
          we = 1'b1; waddr = base + AW'(j_q);
          wdata = (j_q < (len_cl >> 2)) ? nz : 8'd96 + (nz >> 2);
          j_d = j_q + 7'd1;
        end else begin
          j_d = '0;
          if (v_q == VW'(VOICES - 1)) begin
            gate_d = pscs_pkg::GATE_START; gain_d = 8'd255; muted_d = 1'b0;
            state_d = pscs_pkg::ST_OUT;
          end else begin
            v_d = v_q + VW'(1);
            vnote_d = (v_q == '0) ? note_q + 6'd7 : note_q + 6'd12;
            seed_d = seed_q ^ 8'({2'b00, vnote_d} * 8'd17);
          end
        end
      end
      pscs_pkg::ST_SRD_CUR: begin
        state_d = pscs_pkg::ST_SRD_NXT;
      end
      pscs_pkg::ST_SRD_NXT: begin
        // The head entry arrives now; the neighbor is read for the write-back cycle.
        cur_d = rdata_q;
        raddr = base + AW'(np);
        state_d = pscs_pkg::ST_SWR;
      end
      pscs_pkg::ST_SWR: begin
        we = 1'b1; waddr = base + AW'(head_q[v_q]);
        wdata = filt_on_q ? 8'((9'(cur_q) + 9'(rdata_q)) >> 1) : cur_q;
        mix_d = mix_q + 10'(cur_q) - 10'sd128;
        head_d[v_q] = np;
        if (v_q == VW'(VOICES - 1)) begin
          if (filt_on_q) skip_d = '0;
          state_d = pscs_pkg::ST_MIX;
        end else begin
          v_d = v_q + VW'(1);
          state_d = pscs_pkg::ST_SRD_CUR;
        end
      end
      pscs_pkg::ST_MIX: begin
        clipped_d = 8'(m2);
        state_d = pscs_pkg::ST_SCALE;
      end
      pscs_pkg::ST_SCALE: begin
        if (mode_q == pscs_pkg::MODE_NOP7) begin
          for (int v = 0; v < VOICES; v++) begin
            nl = 9'(plen_q[v]) + 9'(delta);
            if (nl < 9'sd15) nl = 9'sd15;
            if (nl > 9'(MAXD)) nl = 9'(MAXD);
            if (head_q[v] >= 7'(nl)) head_d[v] = '0;
            alen_d[v] = 7'(nl);
          end
        end else begin
          if (outv < 0) level_d = 8'd0;
          else if (outv > 11'sd255) level_d = 8'd255;
          else level_d = 8'(outv);
        end
        state_d = pscs_pkg::ST_OUT;
      end
      pscs_pkg::ST_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          out_load = 1'b1;
          v_d = '0; j_d = '0;
          state_d = pscs_pkg::ST_IDLE;
        end
      end
      default: state_d = pscs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pscs_pkg::ST_IDLE;
      clip_q <= pscs_pkg::CLIP_RESET; filt_q <= pscs_pkg::FILT_RESET;
      for (int v = 0; v < VOICES; v++) begin
        head_q[v] <= '0; alen_q[v] <= 7'd1; plen_q[v] <= '0;
      end
      skip_q <= '0; gate_q <= '0; gain_q <= 8'd255; muted_q <= 1'b1;
      seed_q <= pscs_pkg::SEED_RESET; lfo_q <= '0; rising_q <= 1'b1;
      level_q <= pscs_pkg::MIDSCALE; ovalid_q <= 1'b0; init_q <= 1'b0;
      opwm_q <= pscs_pkg::MIDSCALE; oact_q <= 1'b0;
      clr_q <= '0; v_q <= '0; j_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == pscs_pkg::REG_CLIP) clip_q <= cfg_data_i[6:0];
        else filt_q <= cfg_data_i[4:0];
      end
      head_q <= head_d; alen_q <= alen_d; plen_q <= plen_d;
      skip_q <= skip_d; gate_q <= gate_d; gain_q <= gain_d; muted_q <= muted_d;
      seed_q <= seed_d; lfo_q <= lfo_d; rising_q <= rising_d; level_q <= level_d;
      ovalid_q <= ovalid_d; init_q <= init_d; clr_q <= clr_d;
      if (out_load) begin
        opwm_q <= level_q;
        oact_q <= !muted_q;
      end
      v_q <= v_d; j_q <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d; note_q <= note_d; depth_q <= depth_d;
    vnote_q <= vnote_d; cur_q <= cur_d;
    filt_on_q <= filt_on_d; mix_q <= mix_d; clipped_q <= clipped_d;
  end

endmodule

// ===== hdl/pscs_checker.sv =====
// ----------------------------------------------------------------------------
// pscs_checker
// Port-level checks of the synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
module pscs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] pwm_level_o,
  input logic       active_o
);

  // The block works on one item at a time, so it refuses an item in the next cycle.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("back-to-back accept");

  // A result only goes away through a handshake.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i)) else $error("result dropped");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(pwm_level_o)
    && $stable(active_o))) else $error("stalled result changed");

endmodule

bind plucked_string_chord_synth_top pscs_checker u_pscs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .pwm_level_o(pwm_level_o), .active_o(active_o)
);
